### hdl/mfpp_pkg.sv
`default_nettype none

package mfpp_pkg;

  // Picture geometry.
  localparam int WIDTH  = 240;
  localparam int HEIGHT = 64;

  // Rows laid end to end and cut into 24-pixel groups.
  localparam int PIXEL_COUNT = HEIGHT * WIDTH;
  localparam int GROUP_BITS  = 24;
  localparam int GROUP_COUNT = (PIXEL_COUNT + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GRP_W       = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  // Linear pixel index, and the index divided by eight.
  localparam int IDX_W = $clog2(PIXEL_COUNT);
  localparam int T_W   = IDX_W - 3;

  // Division by three through a reciprocal that rounds down; one correction step follows.
  localparam int DIV_S  = T_W + 2;
  localparam int DIV_R  = (1 << DIV_S) / 3;
  localparam int PROD_W = T_W + DIV_S;
  localparam int DIFF_W = T_W + 2;

  // Register reset value and LCD constants.
  localparam logic [5:0] ROW_LIMIT_RESET = 6'd60;
  localparam logic [7:0] CMD_WRITE_MEM   = 8'h2C;
  localparam logic [7:0] SLOT0_ON        = 8'hC0;
  localparam logic [7:0] SLOT1_ON        = 8'h18;
  localparam logic [7:0] SLOT2_ON        = 8'h03;

  // Action codes of an input item.
  typedef enum logic [1:0] {
    ACT_PLOT  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_EMIT  = 2'd2
  } action_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PDIV,
    S_PRD,
    S_PWR,
    S_EOUT
  } state_t;

endpackage

`default_nettype wire

### hdl/mono_framebuffer_plot_and_pack_unit.sv
`default_nettype none

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+--------------------------------------------
// in_      | input     | in_valid/in_stall | in_action, in_x, in_y, in_set_pixel
// out_     | output    | out_valid/out_stall | out_lcd_byte, out_is_command, out_last
// cfg_     | input     | cfg_wr_en         | cfg_wr_data (row_limit)
//
// A plot runs through accept, divide, read and write back, set by the read-modify-write
// of the frame store RAM. An emit accepts the request and then sends one byte per cycle
// through the output register while the output does not stall: eight data bytes, with the
// command byte first for group zero. A clear writes 640 RAM rows, one row per cycle, and
// the same clearing pass runs after reset before any transfer. Stalls on the output freeze
// byte generation; the last byte may still wait in the output register while the next input transfer is taken.
module mono_framebuffer_plot_and_pack_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_x,
  input  wire logic [7:0] in_y,
  input  wire logic       in_set_pixel,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_lcd_byte,
  output logic            out_is_command,
  output logic            out_last,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data
);

  mfpp_pkg::state_t state_r, state_nxt;

  logic [mfpp_pkg::GRP_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [mfpp_pkg::GRP_W-1:0]  readout_r, readout_nxt;
  logic [mfpp_pkg::GRP_W-1:0]  grp_r, grp_nxt;
  logic [mfpp_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [mfpp_pkg::T_W-1:0]    est_r, est_nxt;
  logic [4:0]                  pos_r, pos_nxt;
  logic                        on_r, on_nxt;
  logic [5:0]                  row_limit_r, row_limit_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic                        cmd_pend_r, cmd_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_cmd_r, out_cmd_nxt;
  logic                        out_last_r, out_last_nxt;

  // RAM port signals.
  logic                        ram_we;
  logic [mfpp_pkg::GRP_W-1:0]  ram_waddr;
  logic [23:0]                 ram_wdata;
  logic                        ram_re;
  logic [mfpp_pkg::GRP_W-1:0]  ram_raddr;
  logic [23:0]                 ram_rdata;

  // Datapath intermediates.
  logic                        in_xfer;
  logic                        in_bounds;
  logic [mfpp_pkg::T_W-1:0]    div_t;
  logic [mfpp_pkg::PROD_W-1:0] div_prod;
  logic [mfpp_pkg::DIFF_W-1:0] div_diff;
  logic [2:0]                  div_rem;
  logic [23:0]                 bit_mask;
  logic [23:0]                 word_sh;
  logic [2:0]                  tri_bits;
  logic [7:0]                  data_byte;
  logic                        out_load;

  mfpp_ram #(
    .DATA_W(24),
    .DEPTH (mfpp_pkg::GROUP_COUNT)
  ) u_frame_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfpp_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      readout_r   <= '0;
      row_limit_r <= mfpp_pkg::ROW_LIMIT_RESET;
      cnt_r       <= '0;
      cmd_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      readout_r   <= readout_nxt;
      row_limit_r <= row_limit_nxt;
      cnt_r       <= cnt_nxt;
      cmd_pend_r  <= cmd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    est_r      <= est_nxt;
    grp_r      <= grp_nxt;
    pos_r      <= pos_nxt;
    on_r       <= on_nxt;
    out_byte_r <= out_byte_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_last_r <= out_last_nxt;
  end

  // Plot bounds check and reciprocal division of the pixel index by 24.
  always_comb begin
    in_bounds = (32'(in_x) < 32'(mfpp_pkg::WIDTH)) && (in_y <= {2'b00, row_limit_r}) &&
                (32'(in_y) < 32'(mfpp_pkg::HEIGHT));
    div_t     = idx_r[mfpp_pkg::IDX_W-1:3];
    div_prod  = mfpp_pkg::PROD_W'(div_t) * mfpp_pkg::PROD_W'(mfpp_pkg::DIV_R);
    div_diff  = mfpp_pkg::DIFF_W'(div_t) - mfpp_pkg::DIFF_W'(3) * mfpp_pkg::DIFF_W'(est_r);
    div_rem   = (div_diff[2:0] >= 3'd3) ? div_diff[2:0] - 3'd3 : div_diff[2:0];
    bit_mask  = 24'(1) << pos_r;
  end

  // Pack three pixel slots of the held group word into one LCD byte.
  always_comb begin
    word_sh   = ram_rdata << (5'(cnt_r) * 5'd3);
    tri_bits  = word_sh[23:21];
    data_byte = (tri_bits[2] ? mfpp_pkg::SLOT0_ON : 8'h00) |
                (tri_bits[1] ? mfpp_pkg::SLOT1_ON : 8'h00) |
                (tri_bits[0] ? mfpp_pkg::SLOT2_ON : 8'h00);
  end

  assign in_stall = (state_r != mfpp_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;

  // Sequencer: next state, RAM accesses and output register loads.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    readout_nxt   = readout_r;
    row_limit_nxt = row_limit_r;
    cnt_nxt       = cnt_r;
    cmd_pend_nxt  = cmd_pend_r;
    idx_nxt       = idx_r;
    est_nxt       = est_r;
    grp_nxt       = grp_r;
    pos_nxt       = pos_r;
    on_nxt        = on_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_cmd_nxt   = out_cmd_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = grp_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = readout_r;

    // A waiting byte leaves on a transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      row_limit_nxt = cfg_wr_data;
    end

    case (state_r)
      mfpp_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == mfpp_pkg::GRP_W'(mfpp_pkg::GROUP_COUNT - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = mfpp_pkg::S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      mfpp_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_action)
            mfpp_pkg::ACT_PLOT: begin
              if (in_bounds) begin
                idx_nxt   = mfpp_pkg::IDX_W'(
                              (mfpp_pkg::HEIGHT - 1 - int'(in_y)) * mfpp_pkg::WIDTH +
                              (mfpp_pkg::WIDTH - 1 - int'(in_x)));
                on_nxt    = in_set_pixel;
                state_nxt = mfpp_pkg::S_PDIV;
              end
            end
            mfpp_pkg::ACT_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = mfpp_pkg::S_CLEAR;
            end
            mfpp_pkg::ACT_EMIT: begin
              ram_re       = 1'b1;
              ram_raddr    = readout_r;
              cmd_pend_nxt = (readout_r == '0);
              cnt_nxt      = '0;
              if (readout_r == mfpp_pkg::GRP_W'(mfpp_pkg::GROUP_COUNT - 1)) begin
                readout_nxt = '0;
              end else begin
                readout_nxt = readout_r + 1'b1;
              end
              state_nxt = mfpp_pkg::S_EOUT;
            end
            default: begin
            end
          endcase
        end
      end

      // Quotient estimate of (index / 8) / 3, at most one too small.
      mfpp_pkg::S_PDIV: begin
        est_nxt   = mfpp_pkg::T_W'(div_prod >> mfpp_pkg::DIV_S);
        state_nxt = mfpp_pkg::S_PRD;
      end

      // Correct the quotient, find the bit in the group and read the group.
      mfpp_pkg::S_PRD: begin
        if (div_diff[2:0] >= 3'd3) begin
          grp_nxt = mfpp_pkg::GRP_W'(est_r) + 1'b1;
        end else begin
          grp_nxt = mfpp_pkg::GRP_W'(est_r);
        end
        pos_nxt   = 5'd23 - {div_rem[1:0], idx_r[2:0]};
        ram_re    = 1'b1;
        ram_raddr = grp_nxt;
        state_nxt = mfpp_pkg::S_PWR;
      end

      // Write the group back with the one pixel changed.
      mfpp_pkg::S_PWR: begin
        ram_we    = 1'b1;
        ram_waddr = grp_r;
        ram_wdata = on_r ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        state_nxt = mfpp_pkg::S_IDLE;
      end

      // One byte per cycle into the output register while it can load; a pending command byte goes first.
      mfpp_pkg::S_EOUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (cmd_pend_r) begin
            out_byte_nxt = mfpp_pkg::CMD_WRITE_MEM;
            out_cmd_nxt  = 1'b1;
            out_last_nxt = 1'b0;
            cmd_pend_nxt = 1'b0;
          end else begin
            out_byte_nxt = data_byte;
            out_cmd_nxt  = 1'b0;
            out_last_nxt = (cnt_r == 3'd7);
            cnt_nxt      = cnt_r + 1'b1;
            if (cnt_r == 3'd7) begin
              state_nxt = mfpp_pkg::S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = mfpp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_lcd_byte   = out_byte_r;
  assign out_is_command = out_cmd_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

### hdl/mfpp_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module mfpp_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 640
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
